// ===== src/pcc_pkg.sv =====
// Shared types and fixed widths for the point-in-cylinder classifier.
package pcc_pkg;

  // Coordinate and derived arithmetic widths
  localparam int CB  = 24;          // coordinate
  localparam int DB  = CB + 1;      // difference of two coordinates
  localparam int PB  = 2 * DB;      // product of two differences
  localparam int SB  = PB + 2;      // sum of up to three products
  localparam int MB  = PB;          // magnitude of a cross component, axis length squared
  localparam int HB  = MB / 2;      // half of a magnitude
  localparam int RDB = 18;          // radius
  localparam int TB  = 16;          // tolerance
  localparam int RB  = RDB + 1;     // inflated radius
  localparam int RRB = 2 * RB;      // inflated radius squared
  localparam int XB  = 2 * MB + 2;  // final compare width
  localparam int IB  = 5;           // result index and count
  localparam int SLB = 4;           // slot field

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_CYLINDERS_IN_USE = 1'b0,
    REG_TOLERANCE        = 1'b1
  } cfg_reg_t;

  // Request codes
  localparam logic REQ_LOAD     = 1'b0;
  localparam logic REQ_CLASSIFY = 1'b1;

  localparam logic [TB-1:0] TOLERANCE_RESET = TB'(3000);

  typedef struct packed {
    logic                  req_type;
    logic [SLB-1:0]        slot;
    logic signed [CB-1:0]  start_x;
    logic signed [CB-1:0]  start_y;
    logic signed [CB-1:0]  start_z;
    logic signed [CB-1:0]  end_x;
    logic signed [CB-1:0]  end_y;
    logic signed [CB-1:0]  end_z;
    logic [RDB-1:0]        radius;
    logic signed [CB-1:0]  point_x;
    logic signed [CB-1:0]  point_y;
    logic signed [CB-1:0]  point_z;
  } in_item_t;

  typedef struct packed {
    logic [IB-1:0] cylinder_index;
    logic          found;
  } out_item_t;

  // One stored cylinder: start point, axis vector, radius
  typedef struct packed {
    logic signed [CB-1:0] sx;
    logic signed [CB-1:0] sy;
    logic signed [CB-1:0] sz;
    logic signed [DB-1:0] dx;
    logic signed [DB-1:0] dy;
    logic signed [DB-1:0] dz;
    logic [RDB-1:0]       rad;
  } cyl_t;

  typedef struct packed {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic signed [CB-1:0] z;
  } point_t;

  // Evaluation pipeline latency in cycles
  localparam int EVAL_LAT = 8;

endpackage

// ===== src/point_cylinder_classifier_core.sv =====
// Top level of the point-in-capped-cylinder classifier: cell ring, sequencer, output register.
//
// Input channel in_valid/in_stall/in_item. A load item (req_type 0) writes one
// cylinder into a table cell and gives no result. A classify item
// (req_type 1) gives one result on out_valid/out_stall/out_item: the lowest
// slot below cylinders_in_use that holds the point, or cylinders_in_use with
// found low.
// A classify item is worked in a single pass before its result is registered:
// the cylinders circulate once around the ring of cells, one per cycle, into
// an 8-stage evaluation pipeline, which then drains. in_stall is high for that
// whole pass; one item is in work at a time. Loads can be taken every cycle
// while idle; a classify item can follow the previous one only once that
// one's result is registered. A finished result sits in the output register
// while the next item is taken; if the receiver stalls and the register is
// still full when the next classify finishes, the block holds that result and
// keeps in_stall high. Configuration is written through cfg_we/cfg_index/cfg_data;
// the user must do so only while idle, as the block does not enforce it.
// Reset (rst, synchronous) sets cylinders_in_use to 0, tolerance to 3000 and
// empties the output; the cylinder table is undefined until loaded.
module point_cylinder_classifier_core #(
  parameter int MAX_CYLINDERS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  pcc_pkg::in_item_t      in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output pcc_pkg::out_item_t     out_item,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [pcc_pkg::TB-1:0] cfg_data
);
  import pcc_pkg::*;

  localparam int TOTAL = MAX_CYLINDERS + EVAL_LAT;
  localparam int CNTW  = $clog2(TOTAL + 1);
  localparam int CMPW  = (CNTW > IB) ? CNTW : IB;
  localparam int SLW   = (SLB > CMPW) ? SLB : CMPW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t         state;
  logic [CNTW-1:0] cnt;
  logic [IB-1:0]  cyl_in_use;
  logic [TB-1:0]  tolerance;
  point_t         pt;
  logic           hit;
  logic [IB-1:0]  hit_idx;

  cyl_t           cells [MAX_CYLINDERS];
  cyl_t           load_cyl;
  logic           shift_en;
  logic           accept;
  logic           load_any;
  logic [CMPW-1:0] cnt_ext;
  logic [CMPW-1:0] lim;
  logic           feed_vld;
  logic           res_vld;
  logic [IB-1:0]  res_tag;
  logic           res_match;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);
  assign load_any = accept && (in_item.req_type == REQ_LOAD)
                    && (SLW'(in_item.slot) < SLW'(MAX_CYLINDERS));
  assign cnt_ext  = CMPW'(cnt);
  assign lim      = (CMPW'(cyl_in_use) < CMPW'(MAX_CYLINDERS)) ? CMPW'(cyl_in_use)
                                                              : CMPW'(MAX_CYLINDERS);
  assign shift_en = (state == ST_SCAN) && (cnt_ext < CMPW'(MAX_CYLINDERS));
  assign feed_vld = shift_en && (cnt_ext < lim);

  // Axis vector is formed once at load time
  always_comb begin
    load_cyl.sx  = in_item.start_x;
    load_cyl.sy  = in_item.start_y;
    load_cyl.sz  = in_item.start_z;
    load_cyl.dx  = DB'(in_item.end_x) - DB'(in_item.start_x);
    load_cyl.dy  = DB'(in_item.end_y) - DB'(in_item.start_y);
    load_cyl.dz  = DB'(in_item.end_z) - DB'(in_item.start_z);
    load_cyl.rad = in_item.radius;
  end

  // Ring of cells; cell 0 feeds the evaluator and wraps to the last cell
  for (genvar i = 0; i < MAX_CYLINDERS; i++) begin : g_cell
    pcc_cell u_cell (
      .clk      (clk),
      .load_en  (load_any && (SLW'(in_item.slot) == SLW'(i))),
      .load_cyl (load_cyl),
      .shift_en (shift_en),
      .shift_in (cells[(i + 1) % MAX_CYLINDERS]),
      .cyl      (cells[i])
    );
  end

  pcc_eval u_eval (
    .clk       (clk),
    .rst       (rst),
    .in_vld    (feed_vld),
    .in_tag    (cnt_ext[IB-1:0]),
    .cyl       (cells[0]),
    .pt        (pt),
    .tol       (tolerance),
    .res_vld   (res_vld),
    .res_tag   (res_tag),
    .res_match (res_match)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cyl_in_use <= '0;
      tolerance  <= TOLERANCE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CYLINDERS_IN_USE: cyl_in_use <= cfg_data[IB-1:0];
        REG_TOLERANCE:        tolerance  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Point is held for the whole pass
  always_ff @(posedge clk) begin
    if (accept && (in_item.req_type == REQ_CLASSIFY)) begin
      pt.x <= in_item.point_x;
      pt.y <= in_item.point_y;
      pt.z <= in_item.point_z;
    end
  end

  // Sequencer, first-match capture and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      hit       <= 1'b0;
      hit_idx   <= '0;
      out_valid <= 1'b0;
      out_item  <= '0;
    end else begin
      if (out_valid && !out_stall && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      if (res_vld && res_match && !hit) begin
        hit     <= 1'b1;
        hit_idx <= res_tag;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && (in_item.req_type == REQ_CLASSIFY)) begin
            state <= ST_SCAN;
            cnt   <= '0;
            hit   <= 1'b0;
          end
        end
        ST_SCAN: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNTW'(TOTAL - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid               <= 1'b1;
            out_item.found          <= hit;
            out_item.cylinder_index <= hit ? hit_idx : cyl_in_use;
            state                   <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== src/pcc_cell.sv =====
// One table cell of the cylinder ring: loads a slot or takes its neighbor's cylinder.
module pcc_cell (
  input  logic          clk,
  input  logic          load_en,
  input  pcc_pkg::cyl_t load_cyl,
  input  logic          shift_en,
  input  pcc_pkg::cyl_t shift_in,
  output pcc_pkg::cyl_t cyl
);
  import pcc_pkg::*;

  // Payload register, no reset: contents undefined until loaded
  always_ff @(posedge clk) begin
    if (load_en) begin
      cyl <= load_cyl;
    end else if (shift_en) begin
      cyl <= shift_in;
    end
  end

endmodule

// ===== src/pcc_eval.sv =====
// Pipelined point-in-capped-cylinder test, one cylinder per cycle.
module pcc_eval (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_vld,
  input  logic [pcc_pkg::IB-1:0] in_tag,
  input  pcc_pkg::cyl_t          cyl,
  input  pcc_pkg::point_t        pt,
  input  logic [pcc_pkg::TB-1:0] tol,
  output logic                   res_vld,
  output logic [pcc_pkg::IB-1:0] res_tag,
  output logic                   res_match
);
  import pcc_pkg::*;

  logic [EVAL_LAT-1:0] vld;
  logic [IB-1:0]       tag [EVAL_LAT];

  // stage 1
  logic signed [DB-1:0] qx1, qy1, qz1, dx1, dy1, dz1;
  logic [RB-1:0]        ri1;
  // stage 2
  logic signed [PB-1:0] qdx2, qdy2, qdz2, ddx2, ddy2, ddz2;
  logic signed [PB-1:0] yz2, zy2, zx2, xz2, xy2, yx2;
  logic [RRB-1:0]       rr2;
  // stage 3
  logic signed [SB-1:0] dot3, len3, cx3, cy3, cz3;
  logic [RRB-1:0]       rr3;
  // stage 4
  logic                 caps4;
  logic [MB-1:0]        mx4, my4, mz4, len4;
  logic [RRB-1:0]       rr4;
  // stage 5
  logic [MB-1:0]        hh5 [3];
  logic [MB-1:0]        hl5 [3];
  logic [MB-1:0]        ll5 [3];
  logic [RB+HB-1:0]     rlhh5, rlhl5, rllh5, rlll5;
  logic                 caps5;
  // stage 6
  logic [XB-1:0]        sq6 [3];
  logic [XB-1:0]        rl6;
  logic                 caps6;
  // stage 7
  logic [XB-1:0]        cr7, rl7;
  logic                 caps7;

  logic signed [SB-1:0] cx_abs, cy_abs, cz_abs;
  logic [MB-1:0]        mags [3];

  assign cx_abs = cx3[SB-1] ? -cx3 : cx3;
  assign cy_abs = cy3[SB-1] ? -cy3 : cy3;
  assign cz_abs = cz3[SB-1] ? -cz3 : cz3;
  assign mags[0] = mx4;
  assign mags[1] = my4;
  assign mags[2] = mz4;

  // Valid and tag travel alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[EVAL_LAT-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    tag[0] <= in_tag;
    for (int i = 1; i < EVAL_LAT; i++) begin
      tag[i] <= tag[i-1];
    end
  end

  // Datapath stages
  always_ff @(posedge clk) begin
    // offsets from the start point, inflated radius
    qx1 <= DB'(pt.x) - DB'(cyl.sx);
    qy1 <= DB'(pt.y) - DB'(cyl.sy);
    qz1 <= DB'(pt.z) - DB'(cyl.sz);
    dx1 <= cyl.dx;
    dy1 <= cyl.dy;
    dz1 <= cyl.dz;
    ri1 <= RB'(cyl.rad) + RB'(tol);

    // pairwise products
    qdx2 <= qx1 * dx1;
    qdy2 <= qy1 * dy1;
    qdz2 <= qz1 * dz1;
    ddx2 <= dx1 * dx1;
    ddy2 <= dy1 * dy1;
    ddz2 <= dz1 * dz1;
    yz2  <= qy1 * dz1;
    zy2  <= qz1 * dy1;
    zx2  <= qz1 * dx1;
    xz2  <= qx1 * dz1;
    xy2  <= qx1 * dy1;
    yx2  <= qy1 * dx1;
    rr2  <= ri1 * ri1;

    // dot product, axis length squared, cross product
    dot3 <= SB'(qdx2) + SB'(qdy2) + SB'(qdz2);
    len3 <= SB'(ddx2) + SB'(ddy2) + SB'(ddz2);
    cx3  <= SB'(yz2) - SB'(zy2);
    cy3  <= SB'(zx2) - SB'(xz2);
    cz3  <= SB'(xy2) - SB'(yx2);
    rr3  <= rr2;

    // cap test and magnitudes
    caps4 <= !dot3[SB-1] && (dot3 <= len3) && (len3 != '0);
    mx4   <= cx_abs[MB-1:0];
    my4   <= cy_abs[MB-1:0];
    mz4   <= cz_abs[MB-1:0];
    len4  <= len3[MB-1:0];
    rr4   <= rr3;

    // half-width partial products
    for (int i = 0; i < 3; i++) begin
      hh5[i] <= mags[i][MB-1:HB] * mags[i][MB-1:HB];
      hl5[i] <= mags[i][MB-1:HB] * mags[i][HB-1:0];
      ll5[i] <= mags[i][HB-1:0] * mags[i][HB-1:0];
    end
    rlhh5 <= rr4[RRB-1:RB] * len4[MB-1:HB];
    rlhl5 <= rr4[RRB-1:RB] * len4[HB-1:0];
    rllh5 <= rr4[RB-1:0] * len4[MB-1:HB];
    rlll5 <= rr4[RB-1:0] * len4[HB-1:0];
    caps5 <= caps4;

    // recombine partial products
    for (int i = 0; i < 3; i++) begin
      sq6[i] <= (XB'(hh5[i]) << (2 * HB)) + (XB'(hl5[i]) << (HB + 1)) + XB'(ll5[i]);
    end
    rl6 <= (XB'(rlhh5) << (RB + HB)) + (XB'(rlhl5) << RB)
         + (XB'(rllh5) << HB) + XB'(rlll5);
    caps6 <= caps5;

    // squared distance times length
    cr7   <= sq6[0] + sq6[1] + sq6[2];
    rl7   <= rl6;
    caps7 <= caps6;

    // final compare
    res_match <= caps7 && (cr7 <= rl7);
  end

  assign res_vld = vld[EVAL_LAT-1];
  assign res_tag = tag[EVAL_LAT-1];

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the point-in-capped-cylinder classifier core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pcc_pkg::*;

  localparam int NUM_SLOTS   = 16;
  localparam int IDLE_LIMIT  = 3000;
  localparam int SETTLE      = 2 * (NUM_SLOTS + EVAL_LAT + 9);
  localparam int NUM_PHASES  = 7;
  localparam int PHASE_ITEMS = 200;
  localparam int HOLD_CYCLES = 300;

  typedef logic signed [127:0] wide_t;
  typedef enum logic {ROW_SEND, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t kind;
    in_item_t  item;
    bit        typed;
    out_item_t result;
    int        count;
    int        tol;
  } row_t;

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;
  logic      cfg_we;
  logic      cfg_index;
  logic [TB-1:0] cfg_data;

  // Predictor copy of table and registers
  longint geo_sx[NUM_SLOTS], geo_sy[NUM_SLOTS], geo_sz[NUM_SLOTS];
  longint geo_ex[NUM_SLOTS], geo_ey[NUM_SLOTS], geo_ez[NUM_SLOTS];
  longint geo_rad[NUM_SLOTS];
  int     slots_searched;
  int     radius_margin;

  out_item_t pending_results[$];
  row_t      directed_rows[$];
  int        errors;
  int        idle_cycles;
  int        loads_sent, points_sent, hits_seen, misses_seen;
  bit        quiet;
  bit        pressure_req;

  point_cylinder_classifier_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #6 clk = ~clk;

  // Saturate to the signed coordinate range
  function automatic logic signed [CB-1:0] clamp_coord(longint v);
    if (v > 64'sd8388607) return CB'(8388607);
    if (v < -64'sd8388608) return CB'(-8388608);
    return CB'(v);
  endfunction

  function automatic in_item_t rand_item();
    logic [255:0] r;
    for (int i = 0; i < 8; i++) r[i*32 +: 32] = $urandom;
    return in_item_t'(r[$bits(in_item_t)-1:0]);
  endfunction

  function automatic in_item_t mk_load(int s, longint sx, longint sy, longint sz,
                                       longint ex, longint ey, longint ez, int rad);
    in_item_t it;
    it = rand_item();
    it.req_type = REQ_LOAD;
    it.slot     = SLB'(s);
    it.start_x  = clamp_coord(sx);
    it.start_y  = clamp_coord(sy);
    it.start_z  = clamp_coord(sz);
    it.end_x    = clamp_coord(ex);
    it.end_y    = clamp_coord(ey);
    it.end_z    = clamp_coord(ez);
    it.radius   = RDB'(rad);
    return it;
  endfunction

  function automatic in_item_t mk_point(longint x, longint y, longint z);
    in_item_t it;
    it = rand_item();
    it.req_type = REQ_CLASSIFY;
    it.point_x  = clamp_coord(x);
    it.point_y  = clamp_coord(y);
    it.point_z  = clamp_coord(z);
    return it;
  endfunction

  // Plausible cylinder: mostly short axes, now and then a long one
  function automatic in_item_t gen_cylinder(int s);
    longint c[3], d[3];
    int rad;
    for (int i = 0; i < 3; i++) begin
      c[i] = longint'($urandom_range(0, 1 << 23)) - (1 << 22);
      if ($urandom_range(0, 9) == 0) d[i] = longint'($urandom_range(0, 1 << 24)) - (1 << 23);
      else d[i] = longint'($urandom_range(0, 40000)) - 20000;
    end
    rad = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 262143) : $urandom_range(0, 200000);
    return mk_load(s, c[0], c[1], c[2], c[0] + d[0], c[1] + d[1], c[2] + d[2], rad);
  endfunction

  // Point aimed at a stored cylinder, near its axis and caps, or anywhere
  function automatic in_item_t gen_point();
    int k, t;
    longint m, p[3], s[3], d[3];
    if ($urandom_range(0, 9) < 3) return mk_point(longint'($signed(CB'($urandom))),
      longint'($signed(CB'($urandom))), longint'($signed(CB'($urandom))));
    k = $urandom_range(0, NUM_SLOTS - 1);
    t = int'($urandom_range(0, 1124)) - 50;
    m = (geo_rad[k] + radius_margin) / 2 + 1;
    s = '{geo_sx[k], geo_sy[k], geo_sz[k]};
    d = '{geo_ex[k] - geo_sx[k], geo_ey[k] - geo_sy[k], geo_ez[k] - geo_sz[k]};
    for (int i = 0; i < 3; i++)
      p[i] = s[i] + d[i] * t / 1024 + longint'($urandom_range(0, 2 * m)) - m;
    return mk_point(p[0], p[1], p[2]);
  endfunction

  // Exact containment test for one slot, all in wide integers
  function automatic bit cylinder_holds(int k, longint px, longint py, longint pz);
    wide_t dx, dy, dz, qx, qy, qz, len, dot, cx, cy, cz, cr2, rr;
    longint ri;
    dx = wide_t'(geo_ex[k] - geo_sx[k]);
    dy = wide_t'(geo_ey[k] - geo_sy[k]);
    dz = wide_t'(geo_ez[k] - geo_sz[k]);
    qx = wide_t'(px - geo_sx[k]);
    qy = wide_t'(py - geo_sy[k]);
    qz = wide_t'(pz - geo_sz[k]);
    len = dx * dx + dy * dy + dz * dz;
    dot = qx * dx + qy * dy + qz * dz;
    if (len == 0) return 1'b0;
    if (dot < 0 || dot > len) return 1'b0;
    cx = qy * dz - qz * dy;
    cy = qz * dx - qx * dz;
    cz = qx * dy - qy * dx;
    cr2 = cx * cx + cy * cy + cz * cz;
    ri = geo_rad[k] + radius_margin;
    rr = wide_t'(ri * ri);
    return cr2 <= rr * len;
  endfunction

  function automatic out_item_t classify_point(in_item_t it);
    out_item_t r;
    int lim;
    lim = (slots_searched > NUM_SLOTS) ? NUM_SLOTS : slots_searched;
    for (int k = 0; k < lim; k++)
      if (cylinder_holds(k, longint'($signed(it.point_x)), longint'($signed(it.point_y)),
                         longint'($signed(it.point_z)))) begin
        r.cylinder_index = IB'(k);
        r.found = 1'b1;
        return r;
      end
    r.cylinder_index = IB'(slots_searched);
    r.found = 1'b0;
    return r;
  endfunction

  // Apply an accepted item to the predictor
  task automatic predict_item(in_item_t it, bit typed, out_item_t typed_result);
    int s;
    if (it.req_type == REQ_LOAD) begin
      s = it.slot;
      geo_sx[s]  = longint'($signed(it.start_x));
      geo_sy[s]  = longint'($signed(it.start_y));
      geo_sz[s]  = longint'($signed(it.start_z));
      geo_ex[s]  = longint'($signed(it.end_x));
      geo_ey[s]  = longint'($signed(it.end_y));
      geo_ez[s]  = longint'($signed(it.end_z));
      geo_rad[s] = longint'(it.radius);
      loads_sent++;
    end else begin
      pending_results = {pending_results, (typed ? typed_result : classify_point(it))};
      points_sent++;
    end
  endtask

  // Starts and ends at a falling edge
  task automatic send_item(in_item_t it, bit typed = 1'b0, out_item_t typed_result = '0);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    predict_item(it, typed, typed_result);
    @(negedge clk);
  endtask

  // Let the block go idle before a register write
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [TB-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_CYLINDERS_IN_USE) slots_searched = int'(value[IB-1:0]);
    else radius_margin = int'(value);
  endtask

  task automatic set_config(int count, int tol);
    drain();
    write_reg(REG_CYLINDERS_IN_USE, TB'(count));
    write_reg(REG_TOLERANCE, TB'(tol));
  endtask

  task automatic report(string field, int want, int got);
    errors++;
    $display("mismatch at %0t: %s expected %0d got %0d", $realtime, field, want, got);
  endtask

  // Result checker and watchdog
  always @(posedge clk) begin
    out_item_t want;
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report("unexpected result, index", 0, out_item.cylinder_index);
        end else begin
          want = pending_results.pop_front();
          if (out_item.cylinder_index !== want.cylinder_index)
            report("cylinder_index", want.cylinder_index, out_item.cylinder_index);
          if (out_item.found !== want.found) report("found", want.found, out_item.found);
          if (want.found) hits_seen++;
          else misses_seen++;
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts, one long hold on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (pressure_req) begin
        pressure_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Directed rows: reset defaults, edge geometry, axis, caps and surface
  task automatic build_directed();
    row_t r;
    r = '{kind: ROW_SEND, item: mk_point(-8388608, 8388607, 0), typed: 1'b1,
          result: '{cylinder_index: 5'd0, found: 1'b0}, count: 0, tol: 0};
    directed_rows = {directed_rows, r};
    r.typed = 1'b0;
    r.item = mk_load(0, 100, 100, 100, 100, 100, 100, 5000);   // zero-length axis
    directed_rows = {directed_rows, r};
    r.item = mk_load(1, 0, 0, 0, 0, 0, 10000, 1000);
    directed_rows = {directed_rows, r};
    r.item = mk_load(2, -8388608, -8388608, -8388608, 8388607, 8388607, 8388607, 262143);
    directed_rows = {directed_rows, r};
    for (int s = 3; s < NUM_SLOTS; s++) begin
      r.item = gen_cylinder(s);
      directed_rows = {directed_rows, r};
    end
    r.kind = ROW_CFG;
    r.count = NUM_SLOTS;
    r.tol = 0;
    directed_rows = {directed_rows, r};
    r.kind = ROW_SEND;
    r.typed = 1'b1;
    r.result = '{cylinder_index: 5'd1, found: 1'b1};
    r.item = mk_point(100, 100, 100);      // skips the zero-length slot
    directed_rows = {directed_rows, r};
    r.item = mk_point(0, 0, 0);            // on axis at the lower cap
    directed_rows = {directed_rows, r};
    r.item = mk_point(0, 0, 10000);        // on axis at the upper cap
    directed_rows = {directed_rows, r};
    r.item = mk_point(1000, 0, 5000);      // on the surface
    directed_rows = {directed_rows, r};
    r.result = '{cylinder_index: 5'd2, found: 1'b1};
    r.item = mk_point(8388607, 8388607, 8388607);
    directed_rows = {directed_rows, r};
    r.item = mk_point(-8388608, -8388608, -8388608);
    directed_rows = {directed_rows, r};
    r.typed = 1'b0;
    r.item = mk_point(1001, 0, 5000);      // just outside the surface
    directed_rows = {directed_rows, r};
  endtask

  initial begin
    int phase_count[NUM_PHASES] = '{16, 5, 31, 0, 17, 3, 16};
    int phase_tol[NUM_PHASES];
    int pick;
    in_item_t it;

    phase_tol = '{3000, 65535, 0, 12345, 100, int'($urandom_range(0, 65535)), 40000};
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_index = REG_CYLINDERS_IN_USE;
    cfg_data = '0;
    errors = 0;
    idle_cycles = 0;
    loads_sent = 0;
    points_sent = 0;
    hits_seen = 0;
    misses_seen = 0;
    quiet = 1'b0;
    pressure_req = 1'b0;
    slots_searched = 0;
    radius_margin = 3000;
    foreach (geo_sx[i]) begin
      geo_sx[i] = 0; geo_sy[i] = 0; geo_sz[i] = 0;
      geo_ex[i] = 0; geo_ey[i] = 0; geo_ez[i] = 0; geo_rad[i] = 0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    build_directed();
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG)
        set_config(directed_rows[i].count, directed_rows[i].tol);
      else
        send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);
    end

    // Random phases over several register settings
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_config(phase_count[ph], phase_tol[ph]);
      quiet = (ph == NUM_PHASES - 1);
      if (ph == 1) pressure_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 25) it = gen_cylinder($urandom_range(0, NUM_SLOTS - 1));
        else if (pick < 90) it = gen_point();
        else it = rand_item();
        send_item(it);
      end
    end

    drain();
    $display("run covered %0d loads and %0d classifications (%0d hits, %0d misses)",
             loads_sent, points_sent, hits_seen, misses_seen);
    $display("over %0d register settings, with stall bursts and one long output hold",
             NUM_PHASES + 2);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
